// ===== design/psb_pkg.sv =====
`default_nettype none
package psb_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_PIXEL = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY_PAL  = 3'd1,
        ST_ZERO_SIZE  = 3'd2,
        ST_EXCEEDS    = 3'd3,
        ST_BAD_INDEX  = 3'd4,
        ST_UNEXPECTED = 3'd5
    } t_status;

    localparam logic [2:0] REG_CANVAS_W  = 3'd0;
    localparam logic [2:0] REG_CANVAS_H  = 3'd1;
    localparam logic [2:0] REG_OFFSET_X  = 3'd2;
    localparam logic [2:0] REG_OFFSET_Y  = 3'd3;
    localparam logic [2:0] REG_FRAME_W   = 3'd4;
    localparam logic [2:0] REG_FRAME_H   = 3'd5;
    localparam logic [2:0] REG_COL_ORDER = 3'd6;
    localparam logic [2:0] REG_PAL_COUNT = 3'd7;

    typedef struct packed {
        logic [15:0] canvas_width;
        logic [15:0] canvas_height;
        logic [7:0]  offset_x;
        logic [7:0]  offset_y;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic        column_order;
        logic [7:0]  palette_count;
    } t_cfg;

    // One queued word: a palette load or a classified result awaiting lookup.
    typedef struct packed {
        logic        is_load;
        logic        we;
        t_status     status;
        logic        frame_end;
        logic [7:0]  idx;
        logic [23:0] color;
        logic [16:0] ax;
        logic [16:0] ay;
    } t_qent;

endpackage
`default_nettype wire

// ===== design/psb_front.sv =====
`default_nettype none
module psb_front import psb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_palette_slot,
    input  wire logic [23:0] i_palette_color,
    input  wire logic [7:0]  i_pixel_index,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_qent            o_ent
);

    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic        r_active, n_active;

    logic        accept;
    logic        col_last, row_last, frame_end;
    t_status     hdr_status;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    assign col_last  = ({1'b0, r_col} + 17'd1) >= {1'b0, i_cfg.frame_width};
    assign row_last  = ({1'b0, r_row} + 17'd1) >= {1'b0, i_cfg.frame_height};
    assign frame_end = col_last && row_last;

    always_comb begin
        if (i_cfg.palette_count == 8'd0) begin
            hdr_status = ST_EMPTY_PAL;
        end else if (i_cfg.canvas_width == 16'd0 || i_cfg.canvas_height == 16'd0 ||
                     i_cfg.frame_width == 16'd0 || i_cfg.frame_height == 16'd0) begin
            hdr_status = ST_ZERO_SIZE;
        end else if (({9'd0, i_cfg.offset_x} + {1'b0, i_cfg.frame_width}) >
                         {1'b0, i_cfg.canvas_width} ||
                     ({9'd0, i_cfg.offset_y} + {1'b0, i_cfg.frame_height}) >
                         {1'b0, i_cfg.canvas_height}) begin
            hdr_status = ST_EXCEEDS;
        end else begin
            hdr_status = ST_OK;
        end
    end

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_active = r_active;
        o_ent    = '0;
        o_ent.ax = {9'd0, i_cfg.offset_x} + {1'b0, r_col};
        o_ent.ay = {9'd0, i_cfg.offset_y} + {1'b0, r_row};
        case (i_action)
            ACT_LOAD: begin
                o_ent.is_load = 1'b1;
                o_ent.idx     = i_palette_slot;
                o_ent.color   = i_palette_color;
            end
            ACT_START: begin
                o_ent.status = hdr_status;
                if (hdr_status == ST_OK) begin
                    n_col    = '0;
                    n_row    = '0;
                    n_active = 1'b1;
                end else begin
                    n_active = 1'b0;
                end
            end
            ACT_PIXEL: begin
                if (!r_active) begin
                    o_ent.status = ST_UNEXPECTED;
                end else if (i_pixel_index >= i_cfg.palette_count ||
                             {1'b0, i_pixel_index} >= PAL_LIMIT) begin
                    o_ent.status = ST_BAD_INDEX;
                    n_active     = 1'b0;
                end else begin
                    o_ent.we        = i_pixel_index != 8'd0;
                    o_ent.idx       = i_pixel_index;
                    o_ent.frame_end = frame_end;
                    if (!i_cfg.column_order) begin
                        if (col_last) begin
                            n_col = '0;
                            n_row = r_row + 16'd1;
                        end else begin
                            n_col = r_col + 16'd1;
                        end
                    end else begin
                        if (row_last) begin
                            n_row = '0;
                            n_col = r_col + 16'd1;
                        end else begin
                            n_row = r_row + 16'd1;
                        end
                    end
                    if (frame_end) begin
                        n_active = 1'b0;
                        n_col    = '0;
                        n_row    = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_active <= 1'b0;
        end else if (accept) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_active <= n_active;
        end
    end

    // The last pixel of a frame always leaves the frame disarmed with cleared counters.
    a_end_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && o_ent.frame_end |=> !r_active && r_col == 16'd0 && r_row == 16'd0)
        else $error("frame end did not disarm the frame");

    // An error word is never a canvas write.
    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_ent.status != ST_OK |-> !o_ent.we && !o_ent.frame_end)
        else $error("error word carries a write");

endmodule
`default_nettype wire

// ===== design/psb_fifo.sv =====
`default_nettype none
module psb_fifo import psb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_data,
    input  wire logic  i_pop,
    output t_qent      o_data,
    output logic       o_empty,
    output logic       o_full
);

    t_qent            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QAW:0]     r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = r_count == '0;
    assign o_full  = r_count == (QAW+1)'(QDEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QAW+1)'(1);
                2'b01:   r_count <= r_count - (QAW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("queue overflow or underflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== design/psb_back.sv =====
`default_nettype none
module psb_back import psb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_canvas_width,
    input  wire t_qent       i_head,
    input  wire logic        i_q_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_write_enable,
    output logic [31:0]      o_canvas_address,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [2:0]       o_status,
    output logic             o_frame_end
);

    logic [23:0] r_pal [PALETTE_DEPTH];

    logic        r_s1_v;
    logic        r_s1_we;
    t_status     r_s1_status;
    logic        r_s1_end;
    logic [16:0] r_s1_ax;
    logic [31:0] r_prod;
    logic [23:0] r_rd;

    logic        r_out_v;
    logic        r_out_we;
    logic [31:0] r_out_addr;
    logic [23:0] r_out_rgb;
    t_status     r_out_status;
    logic        r_out_end;

    logic        out_free, s1_adv, s1_free;
    logic [32:0] prod;
    logic [PAL_AW-1:0] pal_addr;

    assign out_free = !r_out_v || !i_out_stall;
    assign s1_adv   = r_s1_v && out_free;
    assign s1_free  = !r_s1_v || out_free;
    assign o_pop    = !i_q_empty && s1_free;
    assign pal_addr = i_head.idx[PAL_AW-1:0];
    assign prod     = i_head.ay * i_canvas_width;

    // Loads reach the palette in queue order, so a later pixel always sees them.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_head.is_load && {1'b0, i_head.idx} < PAL_LIMIT) begin
                r_pal[pal_addr] <= i_head.color;
            end
            r_rd <= r_pal[pal_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_we     <= i_head.we;
            r_s1_status <= i_head.status;
            r_s1_end    <= i_head.frame_end;
            r_s1_ax     <= i_head.ax;
            r_prod      <= prod[31:0];
        end
        if (s1_adv) begin
            r_out_we     <= r_s1_we;
            r_out_addr   <= r_s1_we ? r_prod + {15'd0, r_s1_ax} : 32'd0;
            r_out_rgb    <= r_s1_we ? r_rd : 24'd0;
            r_out_status <= r_s1_status;
            r_out_end    <= r_s1_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= o_pop;
            end
            if (out_free) begin
                r_out_v <= s1_adv;
            end
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_write_enable   = r_out_we;
    assign o_canvas_address = r_out_addr;
    assign o_red            = r_out_rgb[23:16];
    assign o_green          = r_out_rgb[15:8];
    assign o_blue           = r_out_rgb[7:0];
    assign o_alpha          = r_out_we ? ALPHA_OPAQUE : 8'd0;
    assign o_status         = r_out_status;
    assign o_frame_end      = r_out_end;

    // A word held in the lookup stage stays there while the output is blocked.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !out_free |=> r_s1_v && $stable(r_prod) && $stable(r_s1_we))
        else $error("lookup stage lost a word under stall");

    a_no_pop_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_out_v && i_out_stall |-> !o_pop)
        else $error("queue popped into a full pipeline");

endmodule
`default_nettype wire

// ===== design/palette_sprite_blit.sv =====
// A word goes from the queue to the palette lookup stage and then to the output register.
// Throughput: one word per clock while i_out_stall does not hold the output; each of these
// takes a word every cycle then, and the row multiply is one registered stage.
// Reset (i_rst_n low, synchronous) restores the register defaults, empties the queue and
// the pipeline and disarms the frame; palette entries keep their contents until loaded.
`default_nettype none
module palette_sprite_blit import psb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_palette_slot,
    input  wire logic [23:0] i_palette_color,
    input  wire logic [7:0]  i_pixel_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_write_enable,
    output logic [31:0]      o_canvas_address,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [2:0]       o_status,
    output logic             o_frame_end
);

    t_cfg  r_cfg;
    t_qent push_ent, head_ent;
    logic  push, pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.canvas_width  <= 16'd1;
            r_cfg.canvas_height <= 16'd1;
            r_cfg.offset_x      <= 8'd0;
            r_cfg.offset_y      <= 8'd0;
            r_cfg.frame_width   <= 16'd1;
            r_cfg.frame_height  <= 16'd1;
            r_cfg.column_order  <= 1'b0;
            r_cfg.palette_count <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CANVAS_W:  r_cfg.canvas_width  <= i_cfg_data;
                REG_CANVAS_H:  r_cfg.canvas_height <= i_cfg_data;
                REG_OFFSET_X:  r_cfg.offset_x      <= i_cfg_data[7:0];
                REG_OFFSET_Y:  r_cfg.offset_y      <= i_cfg_data[7:0];
                REG_FRAME_W:   r_cfg.frame_width   <= i_cfg_data;
                REG_FRAME_H:   r_cfg.frame_height  <= i_cfg_data;
                REG_COL_ORDER: r_cfg.column_order  <= i_cfg_data[0];
                REG_PAL_COUNT: r_cfg.palette_count <= i_cfg_data[7:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    psb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_palette_slot  (i_palette_slot),
        .i_palette_color (i_palette_color),
        .i_pixel_index   (i_pixel_index),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_ent           (push_ent)
    );

    psb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_ent),
        .i_pop   (pop),
        .o_data  (head_ent),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    psb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_canvas_width   (r_cfg.canvas_width),
        .i_head           (head_ent),
        .i_q_empty        (q_empty),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_write_enable   (o_write_enable),
        .o_canvas_address (o_canvas_address),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_alpha          (o_alpha),
        .o_status         (o_status),
        .o_frame_end      (o_frame_end)
    );

endmodule
`default_nettype wire
